// File: rtl/nti_pkg.sv
// shared constants and types for the nearest timestamp index block
// no dependencies; imported by every other file in rtl/
`default_nettype none

package nti_pkg;

   localparam int DEFAULT_DEPTH     = 1024;
   localparam int DEFAULT_TIME_BITS = 48;

   localparam int CMD_W    = 2;
   localparam int INDEX_W  = 10;
   localparam int STATUS_W = 2;

   // iteration cap of the search loop
   localparam int SEARCH_CAP = 80;
   localparam int ITER_W     = $clog2(SEARCH_CAP + 1);

   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // port controls of the timestamp store
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } nti_mem_ctl_type;

endpackage

`default_nettype wire

// File: rtl/nti_store.sv
// timestamp store: one write port, one read port, registered read data
// depends on nti_pkg for the port control struct
`default_nettype none

module nti_store #(
   parameter int DEPTH     = nti_pkg::DEFAULT_DEPTH,
   parameter int TIME_BITS = nti_pkg::DEFAULT_TIME_BITS
) (
   input  wire logic                          clock,
   input  wire nti_pkg::nti_mem_ctl_type      ctl,
   input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  wire logic [TIME_BITS-1:0]          wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic      [TIME_BITS-1:0]          rd_data
);
   import nti_pkg::*;

   logic [TIME_BITS-1:0] mem [DEPTH];
   logic [TIME_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/nti_search.sv
// command sequencer: entry count, append and clear, binary search over the store
// depends on nti_pkg; drives the ports of nti_store
`default_nettype none

module nti_search #(
   parameter int DEPTH     = nti_pkg::DEFAULT_DEPTH,
   parameter int TIME_BITS = nti_pkg::DEFAULT_TIME_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [nti_pkg::CMD_W-1:0]       req_cmd,
   input  wire logic [TIME_BITS-1:0]            req_time_value,
   output logic                                 rsp_valid,
   output logic      [nti_pkg::INDEX_W-1:0]     rsp_nearest_index,
   output logic      [nti_pkg::STATUS_W-1:0]    rsp_status,
   output nti_pkg::nti_mem_ctl_type             mem_ctl,
   output logic      [$clog2(DEPTH)-1:0]        mem_wr_addr,
   output logic      [TIME_BITS-1:0]            mem_wr_data,
   output logic      [$clog2(DEPTH)-1:0]        mem_rd_addr,
   input  wire logic [TIME_BITS-1:0]            mem_rd_data
);
   import nti_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_FIRST = 5'b00010,
      ST_LAST  = 5'b00100,
      ST_CMP   = 5'b01000,
      ST_HIGH  = 5'b10000
   } nti_state_type;

   nti_state_type         state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [TIME_BITS-1:0]  t_ff, t_in;
   logic [IDX_W-1:0]      last_ff, last_in;
   logic [CNT_W-1:0]      low_ff, low_in;
   logic [CNT_W-1:0]      high_ff, high_in;
   logic [IDX_W-1:0]      mid_ff, mid_in;
   logic [ITER_W-1:0]     iter_ff, iter_in;
   logic [TIME_BITS-1:0]  dmid_ff, dmid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   // loop head of the search
   logic [CNT_W-1:0]      h_low, h_high;
   logic [ITER_W-1:0]     h_iter;
   logic [CNT_W:0]        h_sum;
   logic [CNT_W-1:0]      h_mid;
   logic                  h_go;
   logic [IDX_W-1:0]      h_fin;

   logic                  accept;
   logic                  full;
   logic [TIME_BITS-1:0]  d_lo, d_hi;
   logic [IDX_W-1:0]      res_idx;
   logic                  res_done;
   logic [IDX_W+INDEX_W-1:0] res_ext;

   assign accept = start && (state_ff == ST_IDLE);
   assign full   = (cnt_ff == CNT_W'(DEPTH));

   always_comb begin
      case (state_ff)
         ST_LAST: begin
            h_low  = '0;
            h_high = cnt_ff;
            h_iter = '0;
         end
         ST_CMP: begin
            h_low  = CNT_W'(mid_ff) + CNT_W'(1);
            h_high = high_ff;
            h_iter = iter_ff;
         end
         default: begin
            h_low  = low_ff;
            h_high = high_ff;
            h_iter = iter_ff;
         end
      endcase
      h_sum = {1'b0, h_low} + {1'b0, h_high};
      h_mid = h_sum[CNT_W:1];
      h_go  = (h_iter < ITER_W'(SEARCH_CAP)) && (h_low <= h_high) &&
              (h_mid <= CNT_W'(last_ff));
      // clamp to the last valid entry
      h_fin = (h_low > CNT_W'(last_ff)) ? last_ff : h_low[IDX_W-1:0];
   end

   // neighbour distances for the between case
   assign d_lo = t_ff - mem_rd_data;
   assign d_hi = dmid_ff - t_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      t_in          = t_ff;
      last_in       = last_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      mid_in        = mid_ff;
      iter_in       = iter_ff;
      dmid_in       = dmid_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      res_idx       = '0;
      res_done      = 1'b0;
      mem_ctl       = '{wr_en: 1'b0, rd_en: 1'b0};
      mem_wr_addr   = cnt_ff[IDX_W-1:0];
      mem_wr_data   = req_time_value;
      mem_rd_addr   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               t_in    = req_time_value;
               last_in = IDX_W'(cnt_ff - CNT_W'(1));
               case (req_cmd)
                  CMD_CLEAR: begin
                     cnt_in        = '0;
                     res_done      = 1'b1;
                     rsp_status_in = STATUS_OK;
                  end
                  CMD_APPEND: begin
                     res_done = 1'b1;
                     if (full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        mem_ctl.wr_en = 1'b1;
                        cnt_in        = cnt_ff + CNT_W'(1);
                        rsp_status_in = STATUS_OK;
                     end
                  end
                  CMD_QUERY: begin
                     if (cnt_ff == '0) begin
                        res_done      = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        mem_rd_addr   = '0;
                        state_in      = ST_FIRST;
                     end
                  end
                  default: begin
                     res_done      = 1'b1;
                     rsp_status_in = STATUS_OK;
                  end
               endcase
            end
         end
         ST_FIRST: begin
            if (t_ff < mem_rd_data) begin
               res_done = 1'b1;
               res_idx  = '0;
            end else begin
               mem_ctl.rd_en = 1'b1;
               mem_rd_addr   = last_ff;
               state_in      = ST_LAST;
            end
         end
         ST_LAST: begin
            if (t_ff > mem_rd_data) begin
               res_done = 1'b1;
               res_idx  = last_ff;
            end else begin
               low_in  = h_low;
               high_in = h_high;
               if (h_go) begin
                  mem_ctl.rd_en = 1'b1;
                  mem_rd_addr   = h_mid[IDX_W-1:0];
                  mid_in        = h_mid[IDX_W-1:0];
                  iter_in       = h_iter + ITER_W'(1);
                  state_in      = ST_CMP;
               end else begin
                  res_done = 1'b1;
                  res_idx  = h_fin;
               end
            end
         end
         ST_CMP: begin
            if (mem_rd_data < t_ff) begin
               low_in = h_low;
               if (h_go) begin
                  mem_ctl.rd_en = 1'b1;
                  mem_rd_addr   = h_mid[IDX_W-1:0];
                  mid_in        = h_mid[IDX_W-1:0];
                  iter_in       = h_iter + ITER_W'(1);
               end else begin
                  res_done = 1'b1;
                  res_idx  = h_fin;
               end
            end else if (mem_rd_data > t_ff) begin
               if (mid_ff == '0) begin
                  res_done = 1'b1;
                  res_idx  = (low_ff > CNT_W'(last_ff)) ? last_ff : low_ff[IDX_W-1:0];
               end else begin
                  high_in       = CNT_W'(mid_ff - IDX_W'(1));
                  dmid_in       = mem_rd_data;
                  mem_ctl.rd_en = 1'b1;
                  mem_rd_addr   = mid_ff - IDX_W'(1);
                  state_in      = ST_HIGH;
               end
            end else begin
               res_done = 1'b1;
               res_idx  = mid_ff;
            end
         end
         ST_HIGH: begin
            if (mem_rd_data < t_ff) begin
               // time lies strictly between entries mid-1 and mid, tie to lower
               res_done = 1'b1;
               res_idx  = (d_lo > d_hi) ? mid_ff : mid_ff - IDX_W'(1);
            end else if (h_go) begin
               mem_ctl.rd_en = 1'b1;
               mem_rd_addr   = h_mid[IDX_W-1:0];
               mid_in        = h_mid[IDX_W-1:0];
               iter_in       = h_iter + ITER_W'(1);
               state_in      = ST_CMP;
            end else begin
               res_done = 1'b1;
               res_idx  = h_fin;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (res_done) begin
         rsp_valid_in = 1'b1;
         if (state_ff != ST_IDLE) begin
            rsp_status_in = STATUS_OK;
         end
         state_in = ST_IDLE;
      end
   end

   assign res_ext      = {{INDEX_W{1'b0}}, res_idx};
   assign rsp_index_in = res_done ? res_ext[INDEX_W-1:0] : rsp_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff          <= t_in;
      last_ff       <= last_in;
      low_ff        <= low_in;
      high_ff       <= high_in;
      mid_ff        <= mid_in;
      iter_ff       <= iter_in;
      dmid_ff       <= dmid_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nearest_index = rsp_index_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

`default_nettype wire

// File: rtl/nearest_timestamp_index_top.sv
// nearest timestamp index: clear/append/query on a sorted timestamp list
// clear, append, unused and empty-list items answer in the cycle after start; busy stays low
// a query reads entry 0 (answers 0 if below it), then the last entry (answers it if above),
// else binary searches, reading mid and at times mid-1 per step; one store read a cycle
// results strobe rsp_valid for one cycle, cannot be stalled; next item starts at that edge
// reset clears the entry count and sequencer; stored timestamps are not cleared
`default_nettype none

module nearest_timestamp_index_top #(
   parameter int DEPTH     = nti_pkg::DEFAULT_DEPTH,
   parameter int TIME_BITS = nti_pkg::DEFAULT_TIME_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [nti_pkg::CMD_W-1:0]     req_cmd,
   input  wire logic [TIME_BITS-1:0]          req_time_value,
   output logic                               rsp_valid,
   output logic      [nti_pkg::INDEX_W-1:0]   rsp_nearest_index,
   output logic      [nti_pkg::STATUS_W-1:0]  rsp_status
);
   import nti_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   // store port wiring between sequencer and memory
   nti_mem_ctl_type       mem_ctl;
   logic [IDX_W-1:0]      mem_wr_addr;
   logic [TIME_BITS-1:0]  mem_wr_data;
   logic [IDX_W-1:0]      mem_rd_addr;
   logic [TIME_BITS-1:0]  mem_rd_data;

   // sequencer: holds the entry count and walks the search one read at a time
   nti_search #(
      .DEPTH     (DEPTH),
      .TIME_BITS (TIME_BITS)
   ) u_search (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_time_value    (req_time_value),
      .rsp_valid         (rsp_valid),
      .rsp_nearest_index (rsp_nearest_index),
      .rsp_status        (rsp_status),
      .mem_ctl           (mem_ctl),
      .mem_wr_addr       (mem_wr_addr),
      .mem_wr_data       (mem_wr_data),
      .mem_rd_addr       (mem_rd_addr),
      .mem_rd_data       (mem_rd_data)
   );

   // timestamp store, registered read data
   nti_store #(
      .DEPTH     (DEPTH),
      .TIME_BITS (TIME_BITS)
   ) u_store (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // non-search commands answer in the next cycle and leave the block idle
   a_quick_cmd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd != CMD_QUERY)) |=> (rsp_valid && !busy))
      else $error("non-query item not answered in one cycle");

   // every item result follows an accepted item or the end of a search
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(start && !busy) || $past(busy)))
      else $error("result without a pending item");

   // full status only comes from an append
   a_full_src: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_FULL)) |->
         $past(start && !busy && (req_cmd == CMD_APPEND)))
      else $error("full status not caused by an append");

   // the sequencer only leaves idle for a query
   a_busy_query: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(req_cmd == CMD_QUERY))
      else $error("sequencer started for a non-query item");

endmodule

`default_nettype wire
